// ===== rtl/djau_pkg.sv =====
// ----------------------------------------------------------------------------
// djau_pkg
// Shared widths, constants and register indexes of the dual encoder joint
// angle unit.
// ----------------------------------------------------------------------------
package djau_pkg;

    // field widths
    localparam int GEAR_W   = 10;
    localparam int TURN_W   = 2;
    localparam int JPOS_W   = 12;
    localparam int JCNT_W   = 19;
    localparam int CPR_W    = 24;
    localparam int CNT_W    = 16;
    localparam int WORD_W   = 16;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 48;
    localparam int MAG_W    = 11;
    localparam int PROD_W   = MAG_W + CPR_W;
    localparam int SHIFT_W  = PROD_W - 10;

    // configuration register indexes
    typedef enum logic [0:0] {
        t_REG_SPI_ZERO = 1'b0,
        t_REG_CPR      = 1'b1
    } t_reg_idx;

    localparam logic [GEAR_W-1:0] SPI_ZERO_RST = 10'd109;
    localparam logic [CPR_W-1:0]  CPR_RST      = 24'd485999;

    // one sector of the absolute encoder, and the seam windows
    localparam logic [CNT_W-1:0]  SECTOR_CNT    = 16'd21845;
    localparam logic [CNT_W-1:0]  SECTOR_CNT_2  = 16'd43690;
    localparam logic [CNT_W-1:0]  FULL_CNT      = 16'd65535;
    localparam logic [CNT_W-1:0]  ABS_LOW_MAX   = 16'd910;
    localparam logic [CNT_W-1:0]  ABS_HIGH_MIN  = 16'd20935;
    localparam logic [GEAR_W-1:0] GEAR_HIGH_MIN = 10'd982;
    localparam logic [GEAR_W-1:0] GEAR_LOW_MAX  = 10'd42;

    // joint position range
    localparam logic [JPOS_W-1:0] HALF_STEPS  = 12'd1536;
    localparam logic [JPOS_W-1:0] JOINT_STEPS = 12'd3072;

    // divide by 3 through reciprocal: (x * RECIP3) >> RECIP_SH, exact for 25 bits
    localparam int                RECIP_W  = 26;
    localparam int                RECIP_SH = 27;
    localparam logic [RECIP_W-1:0] RECIP3  = 26'd44739243;
    localparam int                QUO_W    = 24;

    // output saturation
    localparam logic [JCNT_W-1:0] OUT_POS_LIM = 19'd262143;
    localparam logic [JCNT_W-1:0] OUT_NEG_LIM = 19'd262144;

endpackage

// ===== rtl/dual_encoder_joint_angle_unit.sv =====
// ----------------------------------------------------------------------------
// dual_encoder_joint_angle_unit
// Fuses a 10-bit encoder geared 3:1 with a 16-bit absolute encoder into a
// signed joint position and a scaled joint count.
// ----------------------------------------------------------------------------
//  channel | dir | fields (lowest bit first)
//  s_      | in  | tdata: geared_word[15:0], absolute_count[31:16]
//  m_      | out | tdata: geared_position[9:0], turn_index[11:10],
//          |     |        joint_position[23:12], joint_counts[42:24], zero pad
//  cfg     | in  | i_cfg_we, i_cfg_idx (0 spi_zero, 1 counts_per_rev), i_cfg_wdata
//
//  Five register stages; one transfer per cycle while the output is not stalled.
//  The depth is set by the 35-bit scale multiply and the divide-by-3
//  reciprocal multiply, each with its own stage.
//  All stages advance together when the output stage is empty or taken.
//  Reset clears the valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module dual_encoder_joint_angle_unit
    import djau_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // geared_word, absolute_count
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // geared_position, turn_index,
                                         // joint_position, joint_counts
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CPR_W-1:0]  i_cfg_wdata
);

    logic w_en;

    // configuration registers
    logic [GEAR_W-1:0] r_spi_zero;
    logic [CPR_W-1:0]  r_cpr;

    // stage registers
    logic              r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [GEAR_W-1:0] r_gear1, r_gear2, r_gear3, r_gear4, r_gear5;
    logic [TURN_W-1:0] r_q1;
    logic [CNT_W-1:0]  r_cnt1;
    logic [TURN_W-1:0] r_turn2, r_turn3, r_turn4, r_turn5;
    logic [JPOS_W-1:0] r_pos2, r_pos3, r_pos4, r_pos5;
    logic              r_neg3, r_neg4;
    logic [PROD_W-1:0] r_prod3;
    logic [SHIFT_W+RECIP_W-1:0] r_prod4;
    logic [JCNT_W-1:0] r_jcnt5;

    // next values
    logic [GEAR_W-1:0] n_gear1;
    logic [TURN_W-1:0] n_q1;
    logic [CNT_W-1:0]  n_rem2;
    logic [TURN_W-1:0] n_turn2;
    logic [JPOS_W-1:0] n_pos2;
    logic [JPOS_W:0]   w_sum2;
    logic [MAG_W-1:0]  n_mag3;
    logic [QUO_W-1:0]  w_quo5;
    logic [JCNT_W-1:0] w_lim5;
    logic [JCNT_W-1:0] w_sat5;

    assign w_en     = !r_v5 || m_tready;
    assign s_tready = w_en;

    // write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spi_zero <= SPI_ZERO_RST;
            r_cpr      <= CPR_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                t_REG_SPI_ZERO: r_spi_zero <= i_cfg_wdata[GEAR_W-1:0];
                t_REG_CPR:      r_cpr      <= i_cfg_wdata;
                default:        r_cpr      <= r_cpr;
            endcase
        end
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= s_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // stage 1: remove zero offset, pick raw sector
    always_comb begin
        n_gear1 = s_tdata[WORD_W-1:6] - r_spi_zero;
        if (s_tdata[IN_W-1:WORD_W] == FULL_CNT) begin
            n_q1 = 2'd3;
        end else if (s_tdata[IN_W-1:WORD_W] >= SECTOR_CNT_2) begin
            n_q1 = 2'd2;
        end else if (s_tdata[IN_W-1:WORD_W] >= SECTOR_CNT) begin
            n_q1 = 2'd1;
        end else begin
            n_q1 = 2'd0;
        end
    end

    // stage 2: remainder, seam correction, wrapped joint position
    always_comb begin
        case (r_q1)
            2'd1:    n_rem2 = r_cnt1 - SECTOR_CNT;
            2'd2:    n_rem2 = r_cnt1 - SECTOR_CNT_2;
            2'd3:    n_rem2 = r_cnt1 - FULL_CNT;
            default: n_rem2 = r_cnt1;
        endcase
        n_turn2 = (r_q1 == 2'd3) ? 2'd0 : r_q1;
        if (r_gear1 >= GEAR_HIGH_MIN && n_rem2 <= ABS_LOW_MAX) begin
            n_turn2 = (n_turn2 == 2'd0) ? 2'd2 : n_turn2 - 2'd1;
        end else if (r_gear1 <= GEAR_LOW_MAX && n_rem2 >= ABS_HIGH_MIN) begin
            n_turn2 = (n_turn2 == 2'd2) ? 2'd0 : n_turn2 + 2'd1;
        end
        w_sum2 = {1'b0, n_turn2, r_gear1};
        if (w_sum2 >= {1'b0, HALF_STEPS}) begin
            w_sum2 = w_sum2 - {1'b0, JOINT_STEPS};
        end
        n_pos2 = w_sum2[JPOS_W-1:0];
    end

    // stage 3: magnitude of position
    always_comb begin
        if (r_pos2[JPOS_W-1]) begin
            n_mag3 = MAG_W'(-r_pos2);
        end else begin
            n_mag3 = r_pos2[MAG_W-1:0];
        end
    end

    // stage 5: quotient by 3072, saturate, restore sign
    always_comb begin
        w_quo5 = r_prod4[RECIP_SH +: QUO_W];
        w_lim5 = r_neg4 ? OUT_NEG_LIM : OUT_POS_LIM;
        if (w_quo5 > {{(QUO_W-JCNT_W){1'b0}}, w_lim5}) begin
            w_sat5 = w_lim5;
        end else begin
            w_sat5 = w_quo5[JCNT_W-1:0];
        end
    end

    // move payload through the stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_gear1 <= n_gear1;
            r_q1    <= n_q1;
            r_cnt1  <= s_tdata[IN_W-1:WORD_W];

            r_gear2 <= r_gear1;
            r_turn2 <= n_turn2;
            r_pos2  <= n_pos2;

            r_gear3 <= r_gear2;
            r_turn3 <= r_turn2;
            r_pos3  <= r_pos2;
            r_neg3  <= r_pos2[JPOS_W-1];
            r_prod3 <= PROD_W'(n_mag3) * PROD_W'(r_cpr);

            r_gear4 <= r_gear3;
            r_turn4 <= r_turn3;
            r_pos4  <= r_pos3;
            r_neg4  <= r_neg3;
            r_prod4 <= (SHIFT_W+RECIP_W)'(r_prod3[PROD_W-1:10])
                       * (SHIFT_W+RECIP_W)'(RECIP3);

            r_gear5 <= r_gear4;
            r_turn5 <= r_turn4;
            r_pos5  <= r_pos4;
            r_jcnt5 <= r_neg4 ? -w_sat5 : w_sat5;
        end
    end

    assign m_tvalid = r_v5;
    assign m_tdata  = {5'd0, r_jcnt5, r_pos5, r_turn5, r_gear5};

endmodule

// ===== rtl/djau_checker.sv =====
// ----------------------------------------------------------------------------
// djau_checker
// Port-level checks of the dual encoder joint angle unit, bound to the top.
// ----------------------------------------------------------------------------
module djau_checker
    import djau_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // a stalled transfer holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    // corrected turn stays in 0..2
    a_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[11:10] != 2'd3)
        else $error("turn index out of range");

    // joint position does not fall below -1536
    a_jpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !(m_tdata[23] && m_tdata[22:21] == 2'b00))
        else $error("joint position out of range");

    // a negative count needs a negative position
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[42] |-> m_tdata[23])
        else $error("joint count sign mismatch");

endmodule

bind dual_encoder_joint_angle_unit djau_checker u_djau_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
